@@ rtl/core/bar_pkg.sv @@
// Package for the beeper audio renderer: frame constants, derived widths,
// register and request codes, controller states and control/status structs.
// No dependencies.
package bar_pkg;

  localparam int FRAME_TSTATES    = 65000;
  localparam int FRAME_SAMPLES    = 882;
  localparam int MAX_STEP_TSTATES = 255;
  localparam int RESULTS_PER_STEP = 4;

  localparam int POS_W   = $clog2(FRAME_TSTATES + 1);
  localparam int SUM_W   = $clog2(FRAME_TSTATES + MAX_STEP_TSTATES + 1);
  localparam int SD_W    = $clog2(FRAME_SAMPLES + 1);
  // threshold may run one frame length past the last sample
  localparam int PROD_W  = $clog2((FRAME_SAMPLES + 2) * FRAME_TSTATES + 1);
  localparam int CNT_W   = $clog2(RESULTS_PER_STEP);

  localparam int DELTA_W = 8;
  localparam int PORT_W  = 8;
  localparam int REQ_W   = 2;
  localparam int AMP_W   = 15;
  localparam int POLE_W  = 16;
  localparam int SMP_W   = 16;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 16;

  localparam logic [IDX_W-1:0] REG_AUDIO_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DC_POLE      = 2'd2;

  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd4915;
  localparam logic [POLE_W-1:0] POLE_RESET = 16'd65208;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_MUL,
    S_CHECK,
    S_FMUL,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic advance;
    logic mul;
    logic fmul;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic hit;
    logic more;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/beeper_audio_renderer.sv @@
// Top level of the beeper audio renderer: controller plus datapath.
// Depends on bar_pkg, bar_ctrl and bar_dp.
//
//  channel | direction | handshake        | payload
//  in_     | slave     | tvalid/tready    | tuser = req_type; tdata = tstate_delta, port_low
//  out_    | master    | tvalid/tready    | tdata = sample; tuser = frame_end; tlast = last
//  cfg_    | slave     | valid/ready      | index = register, data = value
//
// In fast mode (audio off) a step goes from idle straight to finish. With audio on,
// a step runs advance, the serial position multiply and the threshold compare, then a
// filter multiply and emit for each emitted sample (at most 4), then finish.
// Output stalls hold the emit state; results sit in one output register.
// Reset is synchronous and needs no clearing pass; cfg writes are always ready.
module beeper_audio_renderer
  import bar_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] tstate_delta, [15:8] port_low
  input  logic [REQ_W-1:0]  in_tuser,   // [1:0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SMP_W-1:0]  out_tdata,  // [15:0] sample
  output logic              out_tuser,  // [0] frame_end
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bar_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req        (in_tuser),
    .in_delta      (in_tdata[DELTA_W-1:0]),
    .in_port       (in_tdata[DELTA_W+PORT_W-1:DELTA_W]),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_sample    (out_tdata),
    .out_frame_end (out_tuser),
    .out_last      (out_tlast)
  );

endmodule

@@ rtl/core/bar_ctrl.sv @@
// Controller for the beeper audio renderer: sequences one CPU step through
// advance, threshold check, filter and emit, or straight to finish with audio off. Depends on bar_pkg.
module bar_ctrl
  import bar_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = sts.enable ? S_ADV : S_FIN;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.hit ? S_FMUL : S_FIN;
      end
      S_FMUL: begin
        cmd.fmul  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the request
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.more ? S_FMUL : S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bar_dp.sv @@
// Datapath for the beeper audio renderer: config registers, frame position,
// sample thresholds, DC blocker and output register. Depends on bar_pkg.
module bar_dp
  import bar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [DELTA_W-1:0] in_delta,
  input  logic [PORT_W-1:0]  in_port,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [SMP_W-1:0]   out_sample,
  output logic               out_frame_end,
  output logic               out_last
);

  localparam int FB_W = POLE_W + SMP_W + 1;
  localparam int Y_W  = SMP_W + 3;

  logic               en_r;
  logic [AMP_W-1:0]   amp_r;
  logic [POLE_W-1:0]  pole_r;

  logic [REQ_W-1:0]   req_r;
  logic [DELTA_W-1:0] delta_r;
  logic [PORT_W-1:0]  port_r;

  logic [POS_W-1:0]   pos_r;
  logic [SD_W-1:0]    sd_r;
  logic [PROD_W-1:0]  thr_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               spk_r;
  logic signed [SMP_W-1:0] prev_in_r, prev_out_r;
  logic signed [FB_W-1:0]  fbprod_r;

  logic               out_valid_r;
  logic [SMP_W-1:0]   out_sample_r;
  logic               out_fe_r, out_last_r;

  logic [SUM_W-1:0]   pos_sum;
  logic [POS_W-1:0]   pos_clamp;
  logic [PROD_W-1:0]  thr_next;
  logic signed [SMP_W-1:0] x_s;
  logic signed [SMP_W:0]   fb_s;
  logic signed [Y_W-1:0]   y_sum;
  logic signed [SMP_W-1:0] y_sat;
  logic               frame_full;

  always_comb begin
    pos_sum   = SUM_W'(pos_r) + SUM_W'(delta_r);
    pos_clamp = (pos_sum > SUM_W'(FRAME_TSTATES)) ? POS_W'(FRAME_TSTATES)
                                                  : pos_sum[POS_W-1:0];
    thr_next  = thr_r + PROD_W'(FRAME_TSTATES);
    x_s       = spk_r ? $signed({1'b0, amp_r}) : -$signed({1'b0, amp_r});
    // floor of product / 2^16
    fb_s      = fbprod_r[FB_W-1:POLE_W];
    y_sum     = Y_W'(x_s) - Y_W'(prev_in_r) + Y_W'(fb_s);
    if (y_sum > Y_W'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y_sum < -Y_W'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sum[SMP_W-1:0];
    end
    frame_full = (sd_r == SD_W'(FRAME_SAMPLES - 1));
  end

  assign sts.enable   = en_r;
  assign sts.hit      = (prod_r >= thr_r);
  assign sts.more     = (cnt_r != CNT_W'(RESULTS_PER_STEP - 1)) && !frame_full &&
                        (prod_r >= thr_next);
  assign sts.out_free = !out_valid_r || out_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      amp_r  <= AMP_RESET;
      pole_r <= POLE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AUDIO_ENABLE: en_r   <= cfg_wdata[0];
        REG_AMPLITUDE:    amp_r  <= cfg_wdata[AMP_W-1:0];
        REG_DC_POLE:      pole_r <= cfg_wdata[POLE_W-1:0];
        default:          ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r   <= in_req;
      delta_r <= in_delta;
      port_r  <= in_port;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(pos_r) * PROD_W'(FRAME_SAMPLES);
    end
    if (cmd.fmul) begin
      fbprod_r <= $signed({1'b0, pole_r}) * prev_out_r;
    end
    if (cmd.emit) begin
      out_sample_r <= y_sat;
      out_fe_r     <= frame_full;
      out_last_r   <= !sts.more;
    end
  end

  // frame and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sd_r        <= '0;
      thr_r       <= PROD_W'(FRAME_TSTATES);
      cnt_r       <= '0;
      spk_r       <= 1'b0;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.advance) begin
        pos_r <= pos_clamp;
        cnt_r <= '0;
      end
      if (cmd.emit) begin
        prev_in_r  <= x_s;
        prev_out_r <= y_sat;
        sd_r       <= sd_r + SD_W'(1);
        thr_r      <= thr_next;
        cnt_r      <= cnt_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        if (sd_r == SD_W'(FRAME_SAMPLES)) begin
          sd_r  <= '0;
          pos_r <= '0;
          thr_r <= PROD_W'(FRAME_TSTATES);
        end
        // speaker sits on even port addresses
        if (!port_r[0]) begin
          if (req_r == REQ_READ) begin
            spk_r <= 1'b0;
          end else if (req_r == REQ_WRITE) begin
            spk_r <= 1'b1;
          end
        end
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_frame_end = out_fe_r;
  assign out_last      = out_last_r;

endmodule
